// ===== rtl/swfr_pkg.sv =====
// Package for the sliding-window sender with fast retransmit.
// Holds field widths, opcodes, timer commands and parameter defaults.
// No dependencies.
package swfr_pkg;

    localparam int SEQ_W = 16;
    localparam int PAY_W = 56;

    localparam int WINDOW_DEF           = 4;
    localparam int STORE_INDEX_BITS_DEF = 3;

    localparam logic [1:0] OP_SEND    = 2'd0;
    localparam logic [1:0] OP_ACK     = 2'd1;
    localparam logic [1:0] OP_TIMEOUT = 2'd2;

    localparam logic [1:0] DUP_THRESHOLD = 2'd3;

    typedef enum logic [1:0] {
        TMR_NONE    = 2'd0,
        TMR_START   = 2'd1,
        TMR_STOP    = 2'd2,
        TMR_RESTART = 2'd3
    } timer_cmd_t;

endpackage

// ===== rtl/sliding_window_sender_fast_retx_core.sv =====
// Sliding-window sender core with fast and timeout retransmission.
// Depends on swfr_pkg (widths, opcodes, timer command type).
//
// Usage:
//   Input channel (in_valid / in_stall) carries one event word: a send with
//   a 21-byte payload, an ACK with its checksum flag, or a timer expiry.
//   Output channel (out_valid / out_stall) returns exactly one result word
//   per event: send status, emitted packet (new or retransmitted), timer
//   command and window-full flag.
//   The event is captured in the input register, then processed against
//   the window state into the result register.
//   Throughput is 1 event per cycle while the receiver does not stall; the
//   state update and the payload store write both complete in the cycle an
//   event moves to the result register, and the base-slot payload is kept
//   in a register so the next event sees it at once.
//   When the receiver stalls, the result register holds and the input
//   register fills; in_stall rises only when both are occupied.
//   Reset clears the window base, next sequence number, duplicate-ACK
//   tracking and both valid flags. Payload store contents are undefined
//   until written; only outstanding slots are ever read.
module sliding_window_sender_fast_retx_core
    import swfr_pkg::*;
#(
    parameter int WINDOW           = WINDOW_DEF,
    parameter int STORE_INDEX_BITS = STORE_INDEX_BITS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,

    input  logic             in_valid,
    output logic             in_stall,
    input  logic [1:0]       opcode,
    input  logic [SEQ_W-1:0] ack_number,
    input  logic             ack_checksum_ok,
    input  logic [PAY_W-1:0] payload_low,
    input  logic [PAY_W-1:0] payload_mid,
    input  logic [PAY_W-1:0] payload_high,

    output logic             out_valid,
    input  logic             out_stall,
    output logic             send_accepted,
    output logic             packet_valid,
    output logic             packet_is_retransmit,
    output logic [SEQ_W-1:0] packet_seq,
    output logic [PAY_W-1:0] out_payload_low,
    output logic [PAY_W-1:0] out_payload_mid,
    output logic [PAY_W-1:0] out_payload_high,
    output logic [1:0]       timer_command,
    output logic             window_full
);

    localparam int DEPTH = 1 << STORE_INDEX_BITS;
    localparam logic [SEQ_W-1:0] WIN = SEQ_W'(WINDOW);

    // window state
    logic [SEQ_W-1:0] base_reg, next_seq_reg, dup_val_reg;
    logic [1:0]       dup_cnt_reg;
    logic [SEQ_W-1:0] base_next, nseq_next, dup_val_next;
    logic [1:0]       dup_cnt_next;

    // payload store and base-slot copy
    logic [PAY_W-1:0] mem_low  [DEPTH];
    logic [PAY_W-1:0] mem_mid  [DEPTH];
    logic [PAY_W-1:0] mem_high [DEPTH];
    logic [PAY_W-1:0] base_low_reg, base_mid_reg, base_high_reg;

    // input register
    logic             s1_valid_reg;
    logic [1:0]       s1_op_reg;
    logic [SEQ_W-1:0] s1_ack_reg;
    logic             s1_ok_reg;
    logic [PAY_W-1:0] s1_low_reg, s1_mid_reg, s1_high_reg;

    // result register
    logic             out_valid_reg;
    logic             acc_reg, pkt_reg, retx_reg, full_reg;
    logic [SEQ_W-1:0] seq_reg;
    logic [PAY_W-1:0] olow_reg, omid_reg, ohigh_reg;
    timer_cmd_t       tmr_reg;

    logic             advance, load;
    logic [SEQ_W-1:0] outst, outst_after, ack_d;
    logic             wr_en, emit_base, r_acc, r_pkt, r_retx, r_full;
    logic [SEQ_W-1:0] r_seq;
    timer_cmd_t       r_tmr;
    logic [PAY_W-1:0] r_low, r_mid, r_high;
    logic [STORE_INDEX_BITS-1:0] wslot, rslot;
    logic [SEQ_W-1:0] base_commit;

    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;
    assign load     = in_valid && !in_stall;

    always_comb
    begin
        outst        = next_seq_reg - base_reg;
        ack_d        = s1_ack_reg - base_reg;
        base_next    = base_reg;
        nseq_next    = next_seq_reg;
        dup_val_next = dup_val_reg;
        dup_cnt_next = dup_cnt_reg;
        wr_en        = 1'b0;
        emit_base    = 1'b0;
        r_acc        = 1'b0;
        r_pkt        = 1'b0;
        r_retx       = 1'b0;
        r_seq        = '0;
        r_tmr        = TMR_NONE;

        case (s1_op_reg)
            OP_SEND:
            begin
                if (outst < WIN)
                begin
                    wr_en     = 1'b1;
                    r_acc     = 1'b1;
                    r_pkt     = 1'b1;
                    r_seq     = next_seq_reg;
                    nseq_next = next_seq_reg + 1'b1;
                    if (base_reg == next_seq_reg)
                    begin
                        r_tmr = TMR_START;
                    end
                end
            end
            OP_ACK:
            begin
                if (s1_ok_reg)
                begin
                    if (ack_d < outst)
                    begin
                        base_next = s1_ack_reg + 1'b1;
                        r_tmr     = (base_next == next_seq_reg) ? TMR_STOP : TMR_RESTART;
                    end
                    else if (ack_d[SEQ_W-1])
                    begin
                        // ack behind base: duplicate
                        if (dup_cnt_reg != 2'd0 && dup_val_reg == s1_ack_reg)
                        begin
                            dup_cnt_next = dup_cnt_reg + 2'd1;
                        end
                        else
                        begin
                            dup_val_next = s1_ack_reg;
                            dup_cnt_next = 2'd1;
                        end
                        if (dup_cnt_next == DUP_THRESHOLD)
                        begin
                            dup_cnt_next = 2'd0;
                            emit_base    = (outst != '0);
                        end
                        r_tmr = (base_reg == next_seq_reg) ? TMR_STOP : TMR_RESTART;
                    end
                end
            end
            OP_TIMEOUT:
            begin
                dup_cnt_next = 2'd0;
                if (outst != '0)
                begin
                    emit_base = 1'b1;
                    r_tmr     = TMR_RESTART;
                end
                else
                begin
                    r_tmr = TMR_STOP;
                end
            end
            default:
            begin
            end
        endcase

        if (emit_base)
        begin
            r_pkt  = 1'b1;
            r_retx = 1'b1;
            r_seq  = base_reg;
        end

        if (!r_pkt)
        begin
            r_low  = '0;
            r_mid  = '0;
            r_high = '0;
        end
        else if (emit_base)
        begin
            r_low  = base_low_reg;
            r_mid  = base_mid_reg;
            r_high = base_high_reg;
        end
        else
        begin
            r_low  = s1_low_reg;
            r_mid  = s1_mid_reg;
            r_high = s1_high_reg;
        end

        outst_after = nseq_next - base_next;
        r_full      = (outst_after >= WIN);
    end

    assign base_commit = advance ? base_next : base_reg;
    assign wslot       = next_seq_reg[STORE_INDEX_BITS-1:0];
    assign rslot       = base_commit[STORE_INDEX_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= '0;
            next_seq_reg  <= '0;
            dup_val_reg   <= '0;
            dup_cnt_reg   <= 2'd0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                base_reg     <= base_next;
                next_seq_reg <= nseq_next;
                dup_val_reg  <= dup_val_next;
                dup_cnt_reg  <= dup_cnt_next;
            end
            if (load)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_op_reg   <= opcode;
            s1_ack_reg  <= ack_number;
            s1_ok_reg   <= ack_checksum_ok;
            s1_low_reg  <= payload_low;
            s1_mid_reg  <= payload_mid;
            s1_high_reg <= payload_high;
        end
        if (advance)
        begin
            acc_reg   <= r_acc;
            pkt_reg   <= r_pkt;
            retx_reg  <= r_retx;
            seq_reg   <= r_seq;
            olow_reg  <= r_low;
            omid_reg  <= r_mid;
            ohigh_reg <= r_high;
            tmr_reg   <= r_tmr;
            full_reg  <= r_full;
        end
    end

    // store write, base-slot read with write bypass
    always_ff @(posedge clk)
    begin
        if (advance && wr_en)
        begin
            mem_low[wslot]  <= s1_low_reg;
            mem_mid[wslot]  <= s1_mid_reg;
            mem_high[wslot] <= s1_high_reg;
        end
        if (advance && wr_en && wslot == rslot)
        begin
            base_low_reg  <= s1_low_reg;
            base_mid_reg  <= s1_mid_reg;
            base_high_reg <= s1_high_reg;
        end
        else
        begin
            base_low_reg  <= mem_low[rslot];
            base_mid_reg  <= mem_mid[rslot];
            base_high_reg <= mem_high[rslot];
        end
    end

    assign out_valid            = out_valid_reg;
    assign send_accepted        = acc_reg;
    assign packet_valid         = pkt_reg;
    assign packet_is_retransmit = retx_reg;
    assign packet_seq           = seq_reg;
    assign out_payload_low      = olow_reg;
    assign out_payload_mid      = omid_reg;
    assign out_payload_high     = ohigh_reg;
    assign timer_command        = tmr_reg;
    assign window_full          = full_reg;

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for sliding_window_sender_fast_retx_core.
// Depends on swfr_pkg; predicts each result word and compares it field by field.
module tb_top;
    import swfr_pkg::*;

    localparam int WIN            = WINDOW_DEF;
    localparam int SLOTS          = 1 << STORE_INDEX_BITS_DEF;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int MAX_WAIT       = 8;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_WORDS   = 1400;
    localparam int DRAIN_CYCLES   = 10;

    typedef struct packed {
        logic             send_accepted;
        logic             packet_valid;
        logic             packet_is_retransmit;
        logic [SEQ_W-1:0] packet_seq;
        logic [PAY_W-1:0] pay_low;
        logic [PAY_W-1:0] pay_mid;
        logic [PAY_W-1:0] pay_high;
        timer_cmd_t       timer;
        logic             window_full;
    } result_word_t;

    class window_scoreboard;
        logic [SEQ_W-1:0] base_seq;
        logic [SEQ_W-1:0] next_seq;
        logic [SEQ_W-1:0] dup_value;
        int unsigned      dup_count;
        logic [PAY_W-1:0] slot_low[SLOTS];
        logic [PAY_W-1:0] slot_mid[SLOTS];
        logic [PAY_W-1:0] slot_high[SLOTS];
        result_word_t     expected_q[$];
        int unsigned      errors;

        function new();
            base_seq  = '0;
            next_seq  = '0;
            dup_value = '0;
            dup_count = 0;
            errors    = 0;
            foreach (slot_low[i])
            begin
                slot_low[i]  = '0;
                slot_mid[i]  = '0;
                slot_high[i] = '0;
            end
        endfunction

        function logic [SEQ_W-1:0] in_flight();
            return next_seq - base_seq;
        endfunction

        function result_word_t base_packet();
            result_word_t r;
            int unsigned  s;
            s = base_seq % SLOTS;
            r = '0;
            r.packet_valid         = 1'b1;
            r.packet_is_retransmit = 1'b1;
            r.packet_seq           = base_seq;
            r.pay_low              = slot_low[s];
            r.pay_mid              = slot_mid[s];
            r.pay_high             = slot_high[s];
            return r;
        endfunction

        function void note_word(logic [1:0] op, logic [SEQ_W-1:0] ack, logic ok,
                                logic [PAY_W-1:0] pl, logic [PAY_W-1:0] pm,
                                logic [PAY_W-1:0] ph);
            result_word_t     r;
            logic [SEQ_W-1:0] ack_gap;
            int unsigned      s;
            r = '0;
            case (op)
                OP_SEND:
                begin
                    if (in_flight() < WIN)
                    begin
                        s = next_seq % SLOTS;
                        slot_low[s]  = pl;
                        slot_mid[s]  = pm;
                        slot_high[s] = ph;
                        if (base_seq == next_seq)
                            r.timer = TMR_START;
                        r.send_accepted = 1'b1;
                        r.packet_valid  = 1'b1;
                        r.packet_seq    = next_seq;
                        r.pay_low       = pl;
                        r.pay_mid       = pm;
                        r.pay_high      = ph;
                        next_seq = next_seq + 1'b1;
                    end
                end
                OP_ACK:
                begin
                    if (ok)
                    begin
                        ack_gap = ack - base_seq;
                        if (ack_gap < in_flight())
                        begin
                            base_seq = ack + 1'b1;
                            r.timer = (base_seq == next_seq) ? TMR_STOP : TMR_RESTART;
                        end
                        else if (ack_gap[SEQ_W-1])
                        begin
                            if (dup_count != 0 && dup_value == ack)
                                dup_count++;
                            else
                            begin
                                dup_value = ack;
                                dup_count = 1;
                            end
                            if (dup_count >= DUP_THRESHOLD)
                            begin
                                dup_count = 0;
                                if (in_flight() != 0)
                                    r = base_packet();
                            end
                            r.timer = (base_seq == next_seq) ? TMR_STOP : TMR_RESTART;
                        end
                    end
                end
                OP_TIMEOUT:
                begin
                    dup_count = 0;
                    if (in_flight() != 0)
                    begin
                        r = base_packet();
                        r.timer = TMR_RESTART;
                    end
                    else
                        r.timer = TMR_STOP;
                end
                default: ;
            endcase
            r.window_full = (in_flight() >= WIN);
            expected_q.push_back(r);
        endfunction

        function void field_check(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            end
        endfunction

        function void check_result(result_word_t got);
            result_word_t want;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: result word with none expected, expected nothing, actual %0h",
                         $time, got);
                return;
            end
            want = expected_q.pop_front();
            field_check("send_accepted", 64'(want.send_accepted), 64'(got.send_accepted));
            field_check("packet_valid", 64'(want.packet_valid), 64'(got.packet_valid));
            field_check("packet_is_retransmit", 64'(want.packet_is_retransmit),
                        64'(got.packet_is_retransmit));
            field_check("packet_seq", 64'(want.packet_seq), 64'(got.packet_seq));
            field_check("out_payload_low", 64'(want.pay_low), 64'(got.pay_low));
            field_check("out_payload_mid", 64'(want.pay_mid), 64'(got.pay_mid));
            field_check("out_payload_high", 64'(want.pay_high), 64'(got.pay_high));
            field_check("timer_command", 64'(want.timer), 64'(got.timer));
            field_check("window_full", 64'(want.window_full), 64'(got.window_full));
        endfunction
    endclass

    logic             clk;
    logic             rst_n           = 1'b0;
    logic             in_valid        = 1'b0;
    logic             in_stall;
    logic [1:0]       opcode          = OP_SEND;
    logic [SEQ_W-1:0] ack_number      = '0;
    logic             ack_checksum_ok = 1'b0;
    logic [PAY_W-1:0] payload_low     = '0;
    logic [PAY_W-1:0] payload_mid     = '0;
    logic [PAY_W-1:0] payload_high    = '0;
    logic             out_valid;
    logic             out_stall       = 1'b0;
    logic             send_accepted;
    logic             packet_valid;
    logic             packet_is_retransmit;
    logic [SEQ_W-1:0] packet_seq;
    logic [PAY_W-1:0] out_payload_low;
    logic [PAY_W-1:0] out_payload_mid;
    logic [PAY_W-1:0] out_payload_high;
    logic [1:0]       timer_command;
    logic             window_full;

    result_word_t     dut_word;
    window_scoreboard sb = new();
    bit               quiet = 1'b0;
    bit               hold_req = 1'b0;
    int unsigned      words_sent = 0;
    int unsigned      idle_cycles = 0;

    sliding_window_sender_fast_retx_core #(
        .WINDOW           (WINDOW_DEF),
        .STORE_INDEX_BITS (STORE_INDEX_BITS_DEF)
    ) i_dut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .in_valid             (in_valid),
        .in_stall             (in_stall),
        .opcode               (opcode),
        .ack_number           (ack_number),
        .ack_checksum_ok      (ack_checksum_ok),
        .payload_low          (payload_low),
        .payload_mid          (payload_mid),
        .payload_high         (payload_high),
        .out_valid            (out_valid),
        .out_stall            (out_stall),
        .send_accepted        (send_accepted),
        .packet_valid         (packet_valid),
        .packet_is_retransmit (packet_is_retransmit),
        .packet_seq           (packet_seq),
        .out_payload_low      (out_payload_low),
        .out_payload_mid      (out_payload_mid),
        .out_payload_high     (out_payload_high),
        .timer_command        (timer_command),
        .window_full          (window_full)
    );

    assign dut_word = {send_accepted, packet_valid, packet_is_retransmit, packet_seq,
                       out_payload_low, out_payload_mid, out_payload_high,
                       timer_command, window_full};

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [PAY_W-1:0] rand_pay();
        logic [63:0] w;
        case ($urandom_range(0, 15))
            0:       w = '0;
            1:       w = '1;
            default: w = {$urandom, $urandom};
        endcase
        return w[PAY_W-1:0];
    endfunction

    task automatic put_word(input logic [1:0] op, input logic [SEQ_W-1:0] ack,
                            input logic ok, input logic [PAY_W-1:0] pl,
                            input logic [PAY_W-1:0] pm, input logic [PAY_W-1:0] ph);
        int unsigned gap;
        gap = quiet ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid        <= 1'b1;
        opcode          <= op;
        ack_number      <= ack;
        ack_checksum_ok <= ok;
        payload_low     <= pl;
        payload_mid     <= pm;
        payload_high    <= ph;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        sb.note_word(op, ack, ok, pl, pm, ph);
        if (op != OP_UNUSED)
            words_sent++;
    endtask

    task automatic send_word(input logic [PAY_W-1:0] pl, input logic [PAY_W-1:0] pm,
                             input logic [PAY_W-1:0] ph);
        put_word(OP_SEND, SEQ_W'($urandom), 1'($urandom), pl, pm, ph);
    endtask

    task automatic ack_word(input logic [SEQ_W-1:0] ack, input logic ok);
        put_word(OP_ACK, ack, ok, rand_pay(), rand_pay(), rand_pay());
    endtask

    task automatic timeout_word();
        put_word(OP_TIMEOUT, SEQ_W'($urandom), 1'($urandom), rand_pay(), rand_pay(),
                 rand_pay());
    endtask

    // receiver: random stalls per word, one long hold on request
    initial
    begin
        int unsigned hold;
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold = HOLD_CYCLES;
            end
            else
                hold = quiet ? 0 : $urandom_range(0, MAX_WAIT);
            if (hold != 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                out_stall <= 1'b0;
            end
            do
            begin
                @(posedge clk);
            end
            while (!(rst_n && out_valid));
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(dut_word);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int unsigned      pick;
        int unsigned      burst;
        int unsigned      start_count;
        bit               held;
        logic [SEQ_W-1:0] outs;
        logic [SEQ_W-1:0] dup_ack;

        held = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty window, full window, bad and stray acks, dup acks, timeouts
        timeout_word();
        ack_word(16'h0000, 1'b1);
        ack_word(16'hFFFF, 1'b1);
        put_word(OP_UNUSED, '1, 1'b1, '1, '1, '1);
        send_word('1, '1, '1);
        send_word('0, '0, '0);
        send_word({7{8'hAA}}, {7{8'h55}}, {7{8'hAA}});
        send_word(rand_pay(), rand_pay(), rand_pay());
        send_word(rand_pay(), rand_pay(), rand_pay());
        ack_word(16'd1, 1'b0);
        ack_word(16'd10, 1'b1);
        ack_word(16'd0, 1'b1);
        repeat (3) ack_word(16'd0, 1'b1);
        timeout_word();
        repeat (2) ack_word(16'd0, 1'b1);
        timeout_word();
        ack_word(16'd0, 1'b1);
        send_word(rand_pay(), rand_pay(), rand_pay());
        ack_word(16'd4, 1'b1);
        timeout_word();
        repeat (3) ack_word(16'd4, 1'b1);

        start_count = words_sent;
        while (words_sent - start_count < RANDOM_WORDS)
        begin
            if (!held && words_sent - start_count >= 300)
            begin
                held = 1'b1;
                hold_req = 1'b1;
            end
            if ($urandom_range(0, 149) == 0)
                quiet = !quiet;
            outs = sb.in_flight();
            pick = $urandom_range(0, 99);
            if (pick < 35)
                send_word(rand_pay(), rand_pay(), rand_pay());
            else if (pick < 58)
            begin
                if (outs != 0)
                    ack_word(sb.base_seq + SEQ_W'($urandom_range(0, outs - 1)), 1'b1);
                else
                    ack_word(sb.base_seq - 1'b1, 1'b1);
            end
            else if (pick < 70)
            begin
                dup_ack = sb.base_seq - SEQ_W'($urandom_range(1, 3));
                burst = $urandom_range(2, 4);
                repeat (burst) ack_word(dup_ack, 1'b1);
            end
            else if (pick < 80)
                timeout_word();
            else if (pick < 86)
                ack_word(sb.base_seq + outs + SEQ_W'($urandom_range(0, 32767 - WIN)), 1'b1);
            else if (pick < 92)
                ack_word(SEQ_W'($urandom), 1'b0);
            else if (pick < 96)
                ack_word(SEQ_W'($urandom), 1'($urandom));
            else
                put_word(OP_UNUSED, SEQ_W'($urandom), 1'($urandom), rand_pay(), rand_pay(),
                         rand_pay());
        end
        in_valid <= 1'b0;

        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
